FILE: rtl/max_sum_increasing_subsequence_core_defines.svh
// Assertion macros for the max-sum increasing subsequence core.
// Depends on clk_i and rst_ni being visible in the including module.
`ifndef MAX_SUM_INCREASING_SUBSEQUENCE_CORE_DEFINES_SVH
`define MAX_SUM_INCREASING_SUBSEQUENCE_CORE_DEFINES_SVH

// Property must hold at every clock edge out of reset.
`define MSIS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen at a clock edge out of reset.
`define MSIS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: rtl/msis_pkg.sv
// Shared types for the max-sum increasing subsequence core.
// No dependencies.
package msis_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_e;

endpackage

FILE: rtl/msis_in_if.sv
// Input channel: one sequence element per transaction.
// Valid/ready handshake; no package dependency.
interface msis_in_if #(
  parameter int unsigned VALUE_WIDTH = 16
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value;
  logic                   last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

FILE: rtl/msis_out_if.sv
// Result channel: one sum per sequence.
// Valid/ready handshake; no package dependency.
interface msis_out_if #(
  parameter int unsigned SUM_WIDTH = 23
);
  logic                 valid;
  logic                 ready;
  logic [SUM_WIDTH-1:0] max_sum;
  logic                 overflow;

  modport source (output valid, output max_sum, output overflow, input ready);
  modport sink   (input valid, input max_sum, input overflow, output ready);
endinterface

FILE: rtl/max_sum_increasing_subsequence_core.sv
// Max-sum strictly increasing subsequence core.
// An element accepted while entries are stored is scanned against each of them through the
// one-port store and one compare unit, then updated; with an empty store it goes straight to
// update. Ready only in idle, so no new element is taken until the last one is through. A last
// element's result shows on out_o after its update cycle. A dropped element (store full) skips
// the scan. Reset (async, active low) empties the store, clears running max and the drop flag.
module max_sum_increasing_subsequence_core #(
  parameter int unsigned MAX_LEN     = 256,
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  msis_in_if.sink    in_i,
  msis_out_if.source out_o
);

  // result width: MAX_LEN elements of at most 2^(VALUE_WIDTH-1)-1 each
  localparam int unsigned SUM_WIDTH = VALUE_WIDTH - 1 + $clog2(MAX_LEN);
  localparam int unsigned CW = $clog2(MAX_LEN + 1);                 // count, 0..MAX_LEN
  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1; // store address
  localparam int unsigned BW = SUM_WIDTH + 1;                       // signed best sum
  localparam logic [CW-1:0] FULL = CW'(MAX_LEN);

  // ---------------------------------------------------------------------------
  // Element store: value and best sum per entry, one read and one write port.
  // Entries at or above count_q are never compared, so they need no clearing.
  // ---------------------------------------------------------------------------
  logic signed [VALUE_WIDTH-1:0] value_mem [MAX_LEN];
  logic signed [BW-1:0]          best_mem  [MAX_LEN];

  msis_pkg::state_e state_q, state_d;

  logic [CW-1:0]        count_q, count_d;      // elements stored
  logic [SUM_WIDTH-1:0] rmax_q, rmax_d;        // running max, floored at 0
  logic                 dropped_q, dropped_d;  // element lost to capacity
  logic                 last_q, last_d;
  logic [CW-1:0]        rd_ptr_q, rd_ptr_d;    // next entry to read
  logic                 rd_vld_q;              // read data below is live
  logic                 issue;                 // read issued this cycle
  logic                 scan_done;             // all reads issued and compared

  logic signed [VALUE_WIDTH-1:0] v_q, v_d;     // current element
  logic signed [BW-1:0]          prior_q, prior_d;
  logic signed [VALUE_WIDTH-1:0] rd_val_q;
  logic signed [BW-1:0]          rd_best_q;

  logic                 out_vld_q, out_vld_d;
  logic [SUM_WIDTH-1:0] out_sum_q, out_sum_d;
  logic                 out_ovf_q, out_ovf_d;

  logic                 in_fire;
  logic                 mem_we;
  logic                 out_load;
  logic signed [BW-1:0] sum;

  assign in_i.ready     = (state_q == msis_pkg::ST_IDLE);
  assign in_fire        = in_i.valid && in_i.ready;
  assign out_o.valid    = out_vld_q;
  assign out_o.max_sum  = out_sum_q;
  assign out_o.overflow = out_ovf_q;

  assign issue     = (state_q == msis_pkg::ST_SCAN) && (rd_ptr_q < count_q);
  assign scan_done = (state_q == msis_pkg::ST_SCAN) && !issue && !rd_vld_q;

  // best ending at the current element
  assign sum = BW'(v_q) + prior_q;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    rmax_d    = rmax_q;
    dropped_d = dropped_q;
    last_d    = last_q;
    rd_ptr_d  = rd_ptr_q;
    v_d       = v_q;
    prior_d   = prior_q;
    out_vld_d = out_vld_q;
    out_sum_d = out_sum_q;
    out_ovf_d = out_ovf_q;
    mem_we    = 1'b0;
    out_load  = 1'b0;

    if (out_vld_q && out_o.ready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      msis_pkg::ST_IDLE: begin
        if (in_fire) begin
          v_d      = $signed(in_i.value);
          last_d   = in_i.last;
          prior_d  = '0;
          rd_ptr_d = '0;
          if (count_q == FULL) begin
            // store full: element is discarded, only the flag moves
            dropped_d = 1'b1;
            if (in_i.last) begin
              state_d = msis_pkg::ST_UPDATE;
            end
          end else if (count_q == '0) begin
            state_d = msis_pkg::ST_UPDATE;
          end else begin
            state_d = msis_pkg::ST_SCAN;
          end
        end
      end

      msis_pkg::ST_SCAN: begin
        // shared compare unit: one stored entry per cycle
        if (issue) begin
          rd_ptr_d = rd_ptr_q + CW'(1);
        end
        if (rd_vld_q && (rd_val_q < v_q) && (rd_best_q > prior_q)) begin
          prior_d = rd_best_q;
        end
        if (scan_done) begin
          state_d = msis_pkg::ST_UPDATE;
        end
      end

      msis_pkg::ST_UPDATE: begin
        // a last element waits here until the result register is free
        if (!last_q || !out_vld_q || out_o.ready) begin
          state_d = msis_pkg::ST_IDLE;
          if (last_q) begin
            out_load  = 1'b1;
            out_vld_d = 1'b1;
            out_ovf_d = dropped_q;
            out_sum_d = rmax_q;
            if (count_q != FULL && sum > $signed({1'b0, rmax_q})) begin
              out_sum_d = sum[SUM_WIDTH-1:0];
            end
            count_d   = '0;
            rmax_d    = '0;
            dropped_d = 1'b0;
          end else if (count_q != FULL) begin
            mem_we  = 1'b1;
            count_d = count_q + CW'(1);
            if (sum > $signed({1'b0, rmax_q})) begin
              rmax_d = sum[SUM_WIDTH-1:0];
            end
          end
        end
      end

      default: begin
        state_d = msis_pkg::ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= msis_pkg::ST_IDLE;
      count_q   <= '0;
      rmax_q    <= '0;
      dropped_q <= 1'b0;
      last_q    <= 1'b0;
      rd_ptr_q  <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      rmax_q    <= rmax_d;
      dropped_q <= dropped_d;
      last_q    <= last_d;
      rd_ptr_q  <= rd_ptr_d;
      rd_vld_q  <= issue;
      out_vld_q <= out_vld_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    v_q       <= v_d;
    prior_q   <= prior_d;
    out_sum_q <= out_sum_d;
    out_ovf_q <= out_ovf_d;
  end

  // store: write at the fill point, registered read at the scan pointer
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      value_mem[count_q[AW-1:0]] <= v_q;
      best_mem[count_q[AW-1:0]]  <= sum;
    end
    rd_val_q  <= value_mem[rd_ptr_q[AW-1:0]];
    rd_best_q <= best_mem[rd_ptr_q[AW-1:0]];
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`include "max_sum_increasing_subsequence_core_defines.svh"

  `MSIS_ASSERT(a_count_bound, count_q <= FULL, "element count beyond capacity")
  `MSIS_ASSERT(a_rdvld_in_scan, rd_vld_q |-> state_q == msis_pkg::ST_SCAN, "read outside scan")
  `MSIS_ASSERT(a_scan_complete, scan_done |-> rd_ptr_q == count_q, "scan ended early")
  `MSIS_ASSERT(a_cleared, out_load |=> count_q == '0 && rmax_q == '0 && !dropped_q, "not cleared")

endmodule

FILE: verif/tb_max_sum_increasing_subsequence_core.sv
// Self-checking bench for max_sum_increasing_subsequence_core: directed and random sequences.
// Depends on rtl/msis_in_if.sv and rtl/msis_out_if.sv, and on the core itself.
// Results are predicted per accepted transaction and compared in arrival order.
module tb_max_sum_increasing_subsequence_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_LEN     = 256;
  localparam int unsigned VALUE_WIDTH = 16;
  localparam int unsigned SUM_WIDTH   = 23;
  // Longest time the core may spend on one element: a full scan plus update.
  localparam int unsigned ELEM_CYCLES = MAX_LEN + 3;

  // One expected result transaction.
  typedef struct packed {
    logic [SUM_WIDTH-1:0] max_sum;
    logic                 overflow;
  } sum_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  msis_in_if  #(.VALUE_WIDTH(VALUE_WIDTH)) in_ch ();
  msis_out_if #(.SUM_WIDTH(SUM_WIDTH))     out_ch ();

  max_sum_increasing_subsequence_core #(
    .MAX_LEN    (MAX_LEN),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Prediction state: elements of the sequence under way, their best sums, the
  // floored running maximum and the drop flag. Cleared after each result.
  // ---------------------------------------------------------------------------
  logic signed [VALUE_WIDTH-1:0] seq_vals [MAX_LEN];
  logic signed [24:0]            seq_best [MAX_LEN];
  int unsigned                   seq_len     = 0;
  logic signed [24:0]            seq_max     = '0;
  logic                          seq_dropped = 1'b0;

  sum_result_t pending_sums[$];
  int unsigned error_count = 0;

  // Idle controls: random gaps per transaction when enabled.
  bit          src_idle_en  = 1'b1;
  bit          sink_idle_en = 1'b1;
  // Long receiver hold-off, counted down by the ready driver.
  int unsigned result_hold_cycles = 0;

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Forward rule: best = value + max(0, best of any earlier smaller value).
  // Once the store is full the element only raises the drop flag.
  function automatic void predict_element(input logic [VALUE_WIDTH-1:0] raw,
                                          input logic is_last);
    logic signed [VALUE_WIDTH-1:0] v;
    logic signed [24:0]            prior;
    logic signed [24:0]            best;
    v     = raw;
    prior = '0;
    if (seq_len < MAX_LEN) begin
      for (int j = 0; j < seq_len; j++) begin
        if (seq_vals[j] < v && seq_best[j] > prior) prior = seq_best[j];
      end
      best              = v + prior;
      seq_vals[seq_len] = v;
      seq_best[seq_len] = best;
      if (best > seq_max) seq_max = best;
      seq_len++;
    end else begin
      seq_dropped = 1'b1;
    end
    if (is_last) begin
      pending_sums.push_back('{max_sum: seq_max[SUM_WIDTH-1:0], overflow: seq_dropped});
      seq_len     = 0;
      seq_max     = '0;
      seq_dropped = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: checks result transactions against the oldest expectation, then
  // predicts for the input transaction taken at the same edge. A result can
  // never belong to an element accepted at the same edge, as the result is
  // registered on the edge that leaves the update state, which follows the accept.
  always @(posedge clk_i) begin
    sum_result_t exp_res;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_sums.size() == 0) begin
        report_mismatch($sformatf("unexpected result max_sum=%0d overflow=%0b",
                                  out_ch.max_sum, out_ch.overflow));
      end else begin
        exp_res = pending_sums.pop_front();
        if (out_ch.max_sum !== exp_res.max_sum)
          report_mismatch($sformatf("max_sum got %0d, want %0d",
                                    out_ch.max_sum, exp_res.max_sum));
        if (out_ch.overflow !== exp_res.overflow)
          report_mismatch($sformatf("overflow got %0b, want %0b",
                                    out_ch.overflow, exp_res.overflow));
      end
    end
    if (rst_ni && in_ch.valid && in_ch.ready)
      predict_element(in_ch.value, in_ch.last);
  end

  // ---------------------------------------------------------------------------
  // Result-side ready: a fresh random stall after each result transaction, and
  // a long hold-off whenever a test loads result_hold_cycles.
  // ---------------------------------------------------------------------------
  initial begin : result_ready_drive
    int unsigned stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready)
        stall_left = sink_idle_en ? $urandom_range(0, 5) : 0;
      if (result_hold_cycles > 0) begin
        result_hold_cycles--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Offers one element and returns at the edge where it was taken. valid is
  // left high so a back-to-back element costs no extra NBA in the same step.
  task automatic send_element(input logic [VALUE_WIDTH-1:0] v, input logic is_last);
    int unsigned gap;
    gap = src_idle_en ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    in_ch.last  <= is_last;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic send_sequence(input int elems[$]);
    foreach (elems[i]) send_element(elems[i][VALUE_WIDTH-1:0], i == elems.size() - 1);
  endtask

  // Drops valid and waits until every predicted result has been checked.
  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending_sums.size() != 0);
  endtask

  // Random element: mostly a narrow band so that increasing runs and ties are
  // common, plus the full 16-bit range and the corner values.
  function automatic logic [VALUE_WIDTH-1:0] draw_value();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return VALUE_WIDTH'(int'($urandom_range(0, 40)) - 20);
    if (pick < 85) return VALUE_WIDTH'($urandom_range(0, 65535));
    case ($urandom_range(0, 3))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'hffff;
      default: return 16'h0000;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // One-element sequences: result is max(0, value) at the extremes.
  task automatic test_single_extremes();
    int corner[$];
    corner = '{32767, -32768, 0, -1, 1};
    foreach (corner[i]) send_element(corner[i][VALUE_WIDTH-1:0], 1'b1);
  endtask

  // Hand-picked shapes: interleaved runs, equal values (not strictly
  // increasing), all negative (empty subsequence wins), decreasing, and the
  // most negative value ahead of the most positive.
  task automatic test_mixed_sequences();
    int elems[$];
    elems = '{1, 101, 2, 3, 100, 4, 5};
    send_sequence(elems);
    elems = '{4, 4, 4};
    send_sequence(elems);
    elems = '{-3, -1, -7};
    send_sequence(elems);
    elems = '{9, 7, 5, 3};
    send_sequence(elems);
    elems = '{-32768, 32767};
    send_sequence(elems);
  endtask

  // Full store with the largest strictly increasing sum, run on past capacity
  // so the dropped elements include the one carrying last, then a short
  // sequence to show the drop flag was cleared.
  task automatic test_capacity();
    int elems[$];
    elems = {};
    for (int i = 0; i < MAX_LEN; i++) elems.push_back(32767 - (MAX_LEN - 1) + i);
    for (int i = 0; i < 3; i++) elems.push_back(int'($urandom_range(0, 65535)));
    send_sequence(elems);
    elems = '{5};
    send_sequence(elems);
  endtask

  // Receiver holds off long enough for the core to fill and stall its input
  // while the sender keeps offering; then the sender pauses until drained.
  task automatic test_backpressure();
    src_idle_en        = 1'b0;
    result_hold_cycles = 600;
    for (int s = 0; s < 20; s++) begin
      int unsigned len;
      len = $urandom_range(1, 3);
      for (int k = 0; k < len; k++) send_element(draw_value(), k == len - 1);
    end
    wait_results_drained();
    src_idle_en = 1'b1;
    for (int s = 0; s < 4; s++) send_element(draw_value(), 1'b1);
  endtask

  // Random sequences: mostly short, a few long. Idling is switched off for
  // some sequences on either side so both gap-free and gappy stretches occur.
  task automatic test_random_sequences();
    int unsigned sent;
    int unsigned len;
    int unsigned pick;
    sent = 0;
    while (sent < 80) begin
      pick = $urandom_range(0, 99);
      if (pick < 85)      len = $urandom_range(1, 12);
      else if (pick < 97) len = $urandom_range(13, 40);
      else                len = $urandom_range(41, 100);
      src_idle_en  = ($urandom_range(0, 3) != 0);
      sink_idle_en = ($urandom_range(0, 3) != 0);
      for (int k = 0; k < len; k++) send_element(draw_value(), k == len - 1);
      sent += len;
    end
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_ch.valid = 1'b0;
    in_ch.value = '0;
    in_ch.last  = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_extremes();
    test_mixed_sequences();
    test_capacity();
    test_backpressure();
    test_random_sequences();

    wait_results_drained();
    // Let any stray result surface before judging.
    repeat (ELEM_CYCLES + 8) @(posedge clk_i);

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
